// ===== src/lfps_pkg.sv =====
package lfps_pkg;

  localparam int GAIN_W  = 24;
  localparam int POWER_W = 7;
  localparam int POS_W   = 13;
  localparam int SUM_W   = 16;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  // error: difference of two 13-bit positions
  localparam int ERR_W   = POS_W + 1;
  // derivative: difference of two errors
  localparam int DER_W   = ERR_W + 1;
  // stored integral, clamped to +-INTEGRAL_LIMIT
  localparam int INT_W   = 14;
  localparam int FRAC_W  = 16;

  localparam int P_KP_W  = GAIN_W + 1 + ERR_W;
  localparam int P_KD_W  = GAIN_W + 1 + DER_W;
  localparam int P_KI_W  = GAIN_W + 1 + INT_W;
  localparam int ACC_W   = P_KD_W + 1;
  localparam int CORR_W  = ACC_W - FRAC_W;

  localparam logic signed [DER_W-1:0] INTEGRAL_LIMIT = DER_W'(5000);

  localparam logic [GAIN_W-1:0]  KP_RESET     = GAIN_W'(9272);
  localparam logic [GAIN_W-1:0]  KI_RESET     = GAIN_W'(42);
  localparam logic [GAIN_W-1:0]  KD_RESET     = GAIN_W'(1336033);
  localparam logic [POWER_W-1:0] POWER_RESET  = POWER_W'(77);
  localparam logic [POS_W-1:0]   CENTER_RESET = POS_W'(3000);
  localparam logic [SUM_W-1:0]   LOST_RESET   = SUM_W'(6000);

  typedef enum logic [IDX_W-1:0] {
    REG_KP_GAIN         = 3'd0,
    REG_KI_GAIN         = 3'd1,
    REG_KD_GAIN         = 3'd2,
    REG_MAX_POWER       = 3'd3,
    REG_CENTER_POSITION = 3'd4,
    REG_LOST_THRESHOLD  = 3'd5
  } cfg_index_t;

endpackage

// ===== src/line_follow_pid_steering_top.sv =====
// Line-following PID steering controller.
//
// Input channel (in_valid/in_ready): one word per sensor scan, carrying the
// line position and the reflectance sum. Result channel (out_valid/out_ready):
// one word per input word with left and right drive and a halted flag.
// Configuration port: cfg_wr_en writes cfg_wdata into the register chosen by
// cfg_index (kp, ki, kd gains, max power, center position, lost threshold);
// unknown indexes are dropped. Write it only while the block is idle.
//
// An accepted word sits in the input register; the error, integral, derivative,
// three gain products, truncation, clamp and drive split settle in one pass
// into the result register. Throughput is one word per cycle while out_ready
// is high; the integral and previous-error update closes in that pass.
//
// Reset (rst_n low, synchronous) clears both pipeline valid flags and the
// integral and previous error, and loads the default settings. When the receiver
// stalls, the result register holds its word and the input register fills;
// in_ready drops only when both are full.
module line_follow_pid_steering_top
  import lfps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [POS_W-1:0]   in_line_position,
  input  logic [SUM_W-1:0]   in_reflect_sum,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [POWER_W-1:0] out_left_drive,
  output logic [POWER_W-1:0] out_right_drive,
  output logic               out_halted
);

  // configuration registers
  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [POWER_W-1:0] max_power_r;
  logic [POS_W-1:0]   center_r;
  logic [SUM_W-1:0]   lost_thr_r;

  // controller state
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0] prev_err_r;

  // input register
  logic             in_vld_r;
  logic [POS_W-1:0] pos_r;
  logic [SUM_W-1:0] sum_r;

  // result register
  logic               out_vld_r;
  logic [POWER_W-1:0] left_r, right_r, left_nxt, right_nxt;
  logic               halted_r, halted_nxt;

  logic advance;
  logic lost;
  logic update;

  logic signed [ERR_W-1:0]  err;
  logic signed [DER_W-1:0]  deriv;
  logic signed [DER_W-1:0]  integ_sum;
  logic signed [P_KP_W-1:0] prod_kp;
  logic signed [P_KD_W-1:0] prod_kd;
  logic signed [P_KI_W-1:0] prod_ki;
  logic signed [ACC_W-1:0]  acc;
  logic signed [CORR_W-1:0] corr, corr_lim, lim;

  // result register moves when empty or being taken
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;

  assign lost   = (sum_r >= lost_thr_r);
  assign update = advance && in_vld_r && !lost;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= KP_RESET;
      ki_r        <= KI_RESET;
      kd_r        <= KD_RESET;
      max_power_r <= POWER_RESET;
      center_r    <= CENTER_RESET;
      lost_thr_r  <= LOST_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KP_GAIN:         kp_r        <= cfg_wdata;
        REG_KI_GAIN:         ki_r        <= cfg_wdata;
        REG_KD_GAIN:         kd_r        <= cfg_wdata;
        REG_MAX_POWER:       max_power_r <= cfg_wdata[POWER_W-1:0];
        REG_CENTER_POSITION: center_r    <= cfg_wdata[POS_W-1:0];
        REG_LOST_THRESHOLD:  lost_thr_r  <= cfg_wdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    err   = $signed({1'b0, pos_r}) - $signed({1'b0, center_r});
    deriv = $signed({err[ERR_W-1], err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});

    // integral with clamp to +-limit
    integ_sum = $signed({integ_r[INT_W-1], integ_r}) + $signed({err[ERR_W-1], err});
    if (integ_sum >= INTEGRAL_LIMIT) begin
      integ_nxt = INT_W'(INTEGRAL_LIMIT);
    end else if (integ_sum <= -INTEGRAL_LIMIT) begin
      integ_nxt = INT_W'(-INTEGRAL_LIMIT);
    end else begin
      integ_nxt = integ_sum[INT_W-1:0];
    end

    prod_kp = $signed({1'b0, kp_r}) * err;
    prod_kd = $signed({1'b0, kd_r}) * deriv;
    prod_ki = $signed({1'b0, ki_r}) * integ_nxt;

    acc = $signed({{(ACC_W-P_KP_W){prod_kp[P_KP_W-1]}}, prod_kp})
        + $signed({{(ACC_W-P_KD_W){prod_kd[P_KD_W-1]}}, prod_kd})
        + $signed({{(ACC_W-P_KI_W){prod_ki[P_KI_W-1]}}, prod_ki});

    // drop the fraction, rounding toward zero
    corr = acc[ACC_W-1:FRAC_W]
         + CORR_W'(acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0));

    lim = $signed({{(CORR_W-POWER_W){1'b0}}, max_power_r});
    corr_lim = corr;
    if (corr > lim) begin
      corr_lim = lim;
    end
    if (corr < -lim) begin
      corr_lim = -lim;
    end

    // positive correction slows the left motor, negative the right
    if (corr_lim > 0) begin
      left_nxt  = POWER_W'(lim - corr_lim);
      right_nxt = max_power_r;
    end else begin
      left_nxt  = max_power_r;
      right_nxt = POWER_W'(lim + corr_lim);
    end

    halted_nxt = lost;
    if (lost) begin
      left_nxt  = '0;
      right_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (update) begin
        integ_r    <= integ_nxt;
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pos_r <= in_line_position;
      sum_r <= in_reflect_sum;
    end
    if (advance && in_vld_r) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;
  assign out_halted      = halted_r;

endmodule

// ===== test/tb_line_follow_pid_steering_top.sv =====
`timescale 1ns / 100ps

module tb_line_follow_pid_steering_top;
  import lfps_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 4;
  // Cycles without any handshake on either side before the run is declared hung.
  localparam int IDLE_LIMIT = 1000;
  // Cycles to hold after the last expected word: covers the two-stage pipeline.
  localparam int SETTLE_CYCLES = 4;
  localparam int INTEG_CLAMP = 5000;
  localparam int NOMINAL_POS_MAX = 6000;
  localparam int MAX_PRINTED_ERRORS = 60;
  // Unmapped register index: the block must drop writes to it.
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [POWER_W-1:0] left;
    logic [POWER_W-1:0] right;
    logic               halted;
  } drive_word_t;

  // Predicts the drive word for every accepted scan and checks results in order.
  class steering_scoreboard;
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [POWER_W-1:0] power;
    logic [POS_W-1:0]   center;
    logic [SUM_W-1:0]   lost_at;
    int                 integral;
    int                 last_err;
    drive_word_t        drive_q[$];
    int                 errors;

    function new();
      kp       = KP_RESET;
      ki       = KI_RESET;
      kd       = KD_RESET;
      power    = POWER_RESET;
      center   = CENTER_RESET;
      lost_at  = LOST_RESET;
      integral = 0;
      last_err = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KP_GAIN:         kp = data[GAIN_W-1:0];
        REG_KI_GAIN:         ki = data[GAIN_W-1:0];
        REG_KD_GAIN:         kd = data[GAIN_W-1:0];
        REG_MAX_POWER:       power = data[POWER_W-1:0];
        REG_CENTER_POSITION: center = data[POS_W-1:0];
        REG_LOST_THRESHOLD:  lost_at = data[SUM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_scan(logic [POS_W-1:0] pos, logic [SUM_W-1:0] sum);
      drive_word_t w;
      int          err;
      int          slope;
      longint      acc;
      longint      corr;
      longint      lim;
      w = '{left: '0, right: '0, halted: 1'b1};
      // Line lost: stop both motors and leave the loop state alone.
      if (sum < lost_at) begin
        err = int'(pos) - int'(center);
        slope = err - last_err;
        integral = integral + err;
        if (integral >= INTEG_CLAMP) integral = INTEG_CLAMP;
        else if (integral <= -INTEG_CLAMP) integral = -INTEG_CLAMP;
        last_err = err;
        acc = longint'(kp) * longint'(err) + longint'(kd) * longint'(slope)
            + longint'(ki) * longint'(integral);
        corr = acc / 65536;
        lim = longint'(power);
        if (corr > lim) corr = lim;
        if (corr < -lim) corr = -lim;
        w.halted = 1'b0;
        if (corr > 0) begin
          w.left  = POWER_W'(lim - corr);
          w.right = POWER_W'(lim);
        end else begin
          w.left  = POWER_W'(lim);
          w.right = POWER_W'(lim + corr);
        end
      end
      drive_q.push_back(w);
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void report(string field, int exp_val, int got_val);
      errors++;
      if (errors <= MAX_PRINTED_ERRORS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val,
                 got_val);
    endfunction

    function void check_drive(drive_word_t got);
      drive_word_t exp_w;
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTED_ERRORS)
          $display("%0t: unexpected word: expected none, actual left %0d right %0d halted %0d",
                   $time, got.left, got.right, got.halted);
        return;
      end
      exp_w = drive_q.pop_front();
      if (got.left !== exp_w.left) report("left_drive", exp_w.left, got.left);
      if (got.right !== exp_w.right) report("right_drive", exp_w.right, got.right);
      if (got.halted !== exp_w.halted) report("halted", exp_w.halted, got.halted);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [POS_W-1:0]   in_line_position = '0;
  logic [SUM_W-1:0]   in_reflect_sum = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [POWER_W-1:0] out_left_drive;
  logic [POWER_W-1:0] out_right_drive;
  logic               out_halted;

  // Steady flags switch off the random gaps so back-to-back stretches occur.
  logic               in_steady = 1'b0;
  logic               out_steady = 1'b0;
  int                 idle_cycles = 0;
  int                 walk_pos;

  steering_scoreboard sb = new();

  always #HALF_PERIOD clk = ~clk;

  line_follow_pid_steering_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_line_position (in_line_position),
    .in_reflect_sum   (in_reflect_sum),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_drive   (out_left_drive),
    .out_right_drive  (out_right_drive),
    .out_halted       (out_halted)
  );

  // Monitor: sample both handshakes at the rising edge. Check the result side
  // first; a word accepted at this edge cannot leave at the same edge anyway.
  // The same block runs the watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_drive('{left: out_left_drive, right: out_right_drive, halted: out_halted});
      if (in_valid && in_ready)
        sb.note_scan(in_line_position, in_reflect_sum);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_line_follow_pid_steering_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: for every word, stall a random number of cycles, then hold
  // ready high until a word is taken.
  always begin : result_sink
    int stall;
    @(negedge clk);
    stall = out_steady ? 0 : $urandom_range(0, 11);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && out_ready));
  end

  // Offer one scan word: idle a random gap, then hold valid and payload until
  // the block takes it. Valid stays high across back-to-back words.
  task automatic send_scan(logic [POS_W-1:0] pos, logic [SUM_W-1:0] sum);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_line_position <= pos;
    in_reflect_sum   <= sum;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected word has come out, then let the
  // pipeline settle.
  task automatic hold_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers on an idle block, plus a write to an unmapped
  // index now and then, which must change nothing.
  task automatic apply_setting(logic [CFG_W-1:0] kp, logic [CFG_W-1:0] ki,
                               logic [CFG_W-1:0] kd, logic [CFG_W-1:0] power,
                               logic [CFG_W-1:0] center, logic [CFG_W-1:0] lost_at);
    logic [IDX_W-1:0] idx_list[7];
    logic [CFG_W-1:0] data_list[7];
    idx_list  = '{REG_KP_GAIN, REG_KI_GAIN, REG_KD_GAIN, REG_MAX_POWER,
                  REG_CENTER_POSITION, REG_LOST_THRESHOLD, REG_SPARE};
    data_list = '{kp, ki, kd, power, center, lost_at, CFG_W'($urandom)};
    hold_for_drain();
    for (int k = 0; k < 7; k++) begin
      if (idx_list[k] == REG_SPARE && $urandom_range(0, 1) == 0) continue;
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_wdata <= data_list[k];
      sb.write_reg(idx_list[k], data_list[k]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random scans: mostly a slow walk around the center so the loop tracks with
  // unsaturated corrections, mixed with jumps, full-range positions, lost-line
  // sums and sums right at the threshold.
  task automatic random_batch(int count);
    logic [POS_W-1:0] pos;
    logic [SUM_W-1:0] sum;
    int               thr;
    in_steady  = ($urandom_range(0, 3) == 0);
    out_steady = ($urandom_range(0, 3) == 0);
    walk_pos   = int'(sb.center);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: pos = POS_W'($urandom);
        1, 2, 3: pos = POS_W'($urandom_range(0, NOMINAL_POS_MAX));
        default: begin
          walk_pos = walk_pos + int'($urandom_range(0, 40)) - 20;
          if (walk_pos < 0) walk_pos = 0;
          if (walk_pos > (1 << POS_W) - 1) walk_pos = (1 << POS_W) - 1;
          pos = POS_W'(walk_pos);
        end
      endcase
      thr = int'(sb.lost_at);
      case ($urandom_range(0, 9))
        0: sum = SUM_W'($urandom);
        1: sum = SUM_W'(thr);
        2: sum = (thr > 0) ? SUM_W'(thr - 1) : '0;
        default: sum = (thr > 0) ? SUM_W'($urandom_range(0, thr - 1)) : SUM_W'($urandom);
      endcase
      // Occasionally stop sending until the block has emptied.
      if ($urandom_range(0, 99) == 0) hold_for_drain();
      send_scan(pos, sum);
    end
  endtask

  initial begin : stimulus
    // Hold reset, then release it on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed scans on the reset settings (center 3000, lost at 6000).
    send_scan(POS_W'(3000), SUM_W'(0));       // on the line: zero error
    send_scan(POS_W'(0), SUM_W'(0));          // far left, big derivative
    send_scan(POS_W'(6000), SUM_W'(100));     // far right, big swing back
    send_scan(POS_W'(6000), SUM_W'(5999));    // just below threshold; integral climbs to 3000
    send_scan(POS_W'(6000), SUM_W'(200));
    send_scan(POS_W'(8191), SUM_W'(0));       // position beyond nominal range
    send_scan(POS_W'(8191), SUM_W'(16'hFFFF)); // lost: halt, keep state
    send_scan(POS_W'(0), SUM_W'(6000));       // exactly at threshold: lost
    send_scan(POS_W'(0), SUM_W'(10));
    send_scan(POS_W'(0), SUM_W'(10));
    send_scan(POS_W'(0), SUM_W'(10));         // integral reaches -4000
    send_scan(POS_W'(0), SUM_W'(10));
    send_scan(POS_W'(3001), SUM_W'(0));       // small errors around the center
    send_scan(POS_W'(3002), SUM_W'(0));
    send_scan(POS_W'(2999), SUM_W'(1));
    send_scan(POS_W'(3000), SUM_W'(1000));
    random_batch(60);

    // All gains zero, no power, center at zero: drives stay zero.
    apply_setting('0, '0, '0, '0, '0, CFG_W'(16'hFFFF));
    send_scan(POS_W'(8191), SUM_W'(16'hFFFE));
    send_scan(POS_W'(0), SUM_W'(16'hFFFF));
    random_batch(50);

    // Largest gains, power above nominal, center at top, threshold zero: all lost.
    apply_setting(CFG_W'(24'hFFFFFF), CFG_W'(24'hFFFFFF), CFG_W'(24'hFFFFFF),
                  CFG_W'(127), CFG_W'(13'h1FFF), '0);
    random_batch(12);

    // Largest gains, threshold at the top: line mostly tracked, full saturation both ways.
    apply_setting(CFG_W'(24'hFFFFFF), CFG_W'(24'hFFFFFF), CFG_W'(24'hFFFFFF),
                  CFG_W'(127), CFG_W'(6000), CFG_W'(16'hFFFF));
    send_scan(POS_W'(0), SUM_W'(0));
    send_scan(POS_W'(8191), SUM_W'(0));
    random_batch(50);

    // Unity-scale gains: small errors give corrections inside the clamp.
    apply_setting(CFG_W'(1 << 16), CFG_W'(256), CFG_W'(1 << 14), CFG_W'(100),
                  CFG_W'(3000), CFG_W'(40000));
    random_batch(70);

    // Random settings, mostly moderate, sometimes wide.
    for (int p = 0; p < 5; p++) begin
      apply_setting(
        ($urandom_range(0, 2) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 1 << 17)),
        ($urandom_range(0, 2) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 4096)),
        ($urandom_range(0, 2) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 1 << 17)),
        CFG_W'($urandom_range(0, 127)),
        ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(2000, 4000))
                                    : CFG_W'($urandom_range(0, 8191)),
        ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(3000, 12000))
                                    : CFG_W'($urandom_range(0, 65535)));
      random_batch(55);
    end

    // Back to the reset gains for a last stretch.
    apply_setting(CFG_W'(KP_RESET), CFG_W'(KI_RESET), CFG_W'(KD_RESET),
                  CFG_W'(POWER_RESET), CFG_W'(CENTER_RESET), CFG_W'(LOST_RESET));
    random_batch(40);

    // Drain, then keep watching for stray words.
    hold_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_line_follow_pid_steering_top: PASS");
    end else begin
      $display("tb_line_follow_pid_steering_top: FAIL");
    end
    $finish;
  end

endmodule
